// ===== sv/ctse_pkg.sv =====
// Shared types, constants and arithmetic helpers of the cubic segment evaluator.
package ctse_pkg;

  localparam int FRAC_BITS = 16;

  localparam int T_W       = 31;
  localparam int QUO_W     = 32;
  localparam int NUM_W     = 35;
  localparam int DIV_NW    = NUM_W + FRAC_BITS;
  localparam int HI_W      = DIV_NW - QUO_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int POLY_LAT  = 9;
  localparam int PROD_W    = 63;
  localparam int MR_W      = 64 - FRAC_BITS;
  localparam int SUM_W     = MR_W + 4;

  localparam logic [31:0] S32_MAX_BITS = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN_BITS = 32'h8000_0000;

  typedef logic signed [31:0]       s32_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic signed [MR_W-1:0]   mr_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [T_W-1:0]    dur_t;
  typedef logic        [PROD_W-1:0] prod_t;

  typedef struct packed {
    s32_t p0;
    s32_t v0;
    s32_t v1;
    dur_t t;
    dur_t w;
    dur_t wl;
    s32_t q;
    s32_t a2;
    logic zero;
    logic clip;
  } ctx_t;

  function automatic logic [31:0] abs32(input s32_t v);
    logic [31:0] r;
    r = v[31] ? -v : v;
    return r;
  endfunction

  function automatic mr_t fx_round(input logic neg, input prod_t mag);
    logic [PROD_W:0] s;
    logic [PROD_W:0] sh;
    mr_t r;
    s  = {1'b0, mag} + ({{PROD_W{1'b0}}, 1'b1} << (FRAC_BITS - 1));
    sh = s >> FRAC_BITS;
    r  = sh[MR_W-1:0];
    return neg ? -r : r;
  endfunction

  function automatic sum_t sx32(input s32_t v);
    return {{(SUM_W-32){v[31]}}, v};
  endfunction

  function automatic sum_t sxm(input mr_t v);
    return {{(SUM_W-MR_W){v[MR_W-1]}}, v};
  endfunction

  function automatic logic sat_hit(input sum_t v);
    logic [SUM_W-32:0] hi;
    hi = v[SUM_W-1:31];
    return !((&hi) || !(|hi));
  endfunction

  function automatic s32_t sat_val(input sum_t v);
    s32_t r;
    if (sat_hit(v)) begin
      r = v[SUM_W-1] ? S32_MIN_BITS : S32_MAX_BITS;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ctse_div.sv =====
// Pipelined restoring divider: rounded, saturated n * 2^FRAC_BITS / T, one quotient bit a stage.
module ctse_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  ctse_pkg::num_t  num,
  input  ctse_pkg::ctx_t  ctx_in,
  output logic            valid_out,
  output ctse_pkg::s32_t  quo,
  output logic            clip,
  output ctse_pkg::ctx_t  ctx_out
);

  logic [ctse_pkg::NUM_W-1:0]  mag;
  logic [ctse_pkg::DIV_NW-1:0] nfull;
  logic [ctse_pkg::HI_W-1:0]   hi;
  logic                        ovf;

  logic [ctse_pkg::DIV_STEPS:0] vld_r;
  logic [ctse_pkg::DIV_STEPS:0] ovf_r;
  logic [ctse_pkg::DIV_STEPS:0] neg_r;
  ctse_pkg::dur_t               rem_r   [0:ctse_pkg::DIV_STEPS];
  ctse_pkg::dur_t               rem_nxt [1:ctse_pkg::DIV_STEPS];
  logic [ctse_pkg::QUO_W-1:0]   sh_r    [0:ctse_pkg::DIV_STEPS];
  logic [ctse_pkg::QUO_W-1:0]   sh_nxt  [1:ctse_pkg::DIV_STEPS];
  ctse_pkg::ctx_t               ctx_r   [0:ctse_pkg::DIV_STEPS];
  logic [ctse_pkg::QUO_W-1:0]   trial   [0:ctse_pkg::DIV_STEPS-1];
  logic [ctse_pkg::DIV_STEPS-1:0] ge;

  logic [ctse_pkg::QUO_W-1:0] qq;
  logic                       hit;
  ctse_pkg::s32_t             val;

  logic           vout_r;
  ctse_pkg::s32_t quo_r;
  logic           clip_r;
  ctse_pkg::ctx_t ctxo_r;

  always_comb begin
    mag   = num[ctse_pkg::NUM_W-1] ? -num : num;
    nfull = {mag, {ctse_pkg::FRAC_BITS{1'b0}}} + ctse_pkg::DIV_NW'(ctx_in.t >> 1);
    hi    = nfull[ctse_pkg::DIV_NW-1 -: ctse_pkg::HI_W];
    ovf   = ctse_pkg::QUO_W'(hi) >= ctse_pkg::QUO_W'(ctx_in.t);
  end

  always_comb begin
    for (int i = 0; i < ctse_pkg::DIV_STEPS; i++) begin
      trial[i] = {rem_r[i], sh_r[i][ctse_pkg::QUO_W-1]};
      ge[i]    = trial[i] >= {1'b0, ctx_r[i].t};
      rem_nxt[i+1] = ge[i] ? ctse_pkg::T_W'(trial[i] - {1'b0, ctx_r[i].t})
                           : trial[i][ctse_pkg::T_W-1:0];
      sh_nxt[i+1]  = {sh_r[i][ctse_pkg::QUO_W-2:0], ge[i]};
    end
  end

  always_comb begin
    qq = sh_r[ctse_pkg::DIV_STEPS];
    if (neg_r[ctse_pkg::DIV_STEPS]) begin
      hit = ovf_r[ctse_pkg::DIV_STEPS] || (qq > ctse_pkg::S32_MIN_BITS);
      val = hit ? ctse_pkg::S32_MIN_BITS : -qq;
    end else begin
      hit = ovf_r[ctse_pkg::DIV_STEPS] || qq[ctse_pkg::QUO_W-1];
      val = hit ? ctse_pkg::S32_MAX_BITS : qq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vout_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[ctse_pkg::DIV_STEPS-1:0], valid_in};
      vout_r <= vld_r[ctse_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= ovf ? '0 : ctse_pkg::T_W'(hi);
    sh_r[0]  <= nfull[ctse_pkg::QUO_W-1:0];
    ovf_r[0] <= ovf;
    neg_r[0] <= num[ctse_pkg::NUM_W-1];
    ctx_r[0] <= ctx_in;
    for (int i = 1; i <= ctse_pkg::DIV_STEPS; i++) begin
      rem_r[i] <= rem_nxt[i];
      sh_r[i]  <= sh_nxt[i];
      ovf_r[i] <= ovf_r[i-1];
      neg_r[i] <= neg_r[i-1];
      ctx_r[i] <= ctx_r[i-1];
    end
    quo_r  <= val;
    clip_r <= hit;
    ctxo_r <= ctx_r[ctse_pkg::DIV_STEPS];
  end

  assign valid_out = vout_r;
  assign quo       = quo_r;
  assign clip      = clip_r;
  assign ctx_out   = ctxo_r;

endmodule

// ===== sv/ctse_poly.sv =====
// Pipelined Horner evaluation of position, velocity, acceleration and lookahead velocity from the coefficients.
module ctse_poly (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  input  ctse_pkg::s32_t a3,
  input  ctse_pkg::ctx_t ctx_in,
  output logic           valid_out,
  output ctse_pkg::s32_t pos,
  output ctse_pkg::s32_t vel,
  output ctse_pkg::s32_t acc,
  output ctse_pkg::s32_t lvel,
  output logic           zero,
  output logic           sat
);

  logic [ctse_pkg::POLY_LAT-1:0] vld_r;

  ctse_pkg::prod_t pw1_r, pl1_r;
  logic            neg1_r;
  ctse_pkg::ctx_t  ctx1_r;

  ctse_pkg::mr_t   mw2_r, ml2_r;
  ctse_pkg::ctx_t  ctx2_r;

  ctse_pkg::sum_t  a2x, mwx, mlx, h_s, kw_s, acc_s, kl_s;
  ctse_pkg::s32_t  h3_r, kw3_r, acc3_r, kl3_r;
  ctse_pkg::ctx_t  ctx3_r;
  ctse_pkg::ctx_t  ctx3_nxt;

  ctse_pkg::prod_t ph4_r, pk4_r, pkl4_r;
  logic            nh4_r, nk4_r, nkl4_r;
  ctse_pkg::s32_t  acc4_r;
  ctse_pkg::ctx_t  ctx4_r;

  ctse_pkg::mr_t   hw5_r, kw5_r, kl5_r;
  ctse_pkg::s32_t  acc5_r;
  ctse_pkg::ctx_t  ctx5_r;

  ctse_pkg::sum_t  g_s, vel_s, lv_s;
  ctse_pkg::s32_t  g6_r, vel6_r, lv6_r, acc6_r;
  ctse_pkg::ctx_t  ctx6_r;
  ctse_pkg::ctx_t  ctx6_nxt;

  ctse_pkg::prod_t pg7_r;
  logic            ng7_r;
  ctse_pkg::s32_t  vel7_r, lv7_r, acc7_r;
  ctse_pkg::ctx_t  ctx7_r;

  ctse_pkg::mr_t   gw8_r;
  ctse_pkg::s32_t  vel8_r, lv8_r, acc8_r;
  ctse_pkg::ctx_t  ctx8_r;

  ctse_pkg::sum_t  pos_s;
  ctse_pkg::s32_t  pos_r, vel_r, acc_r, lvel_r;
  logic            zero_r, sat_r;

  always_comb begin
    a2x   = ctse_pkg::sx32(ctx2_r.a2);
    mwx   = ctse_pkg::sxm(mw2_r);
    mlx   = ctse_pkg::sxm(ml2_r);
    h_s   = a2x + mwx;
    kw_s  = (a2x <<< 1) + mwx + (mwx <<< 1);
    acc_s = (a2x <<< 1) + (mwx <<< 1) + (mwx <<< 2);
    kl_s  = (a2x <<< 1) + mlx + (mlx <<< 1);
    g_s   = ctse_pkg::sx32(ctx5_r.v0) + ctse_pkg::sxm(hw5_r);
    vel_s = ctse_pkg::sx32(ctx5_r.v0) + ctse_pkg::sxm(kw5_r);
    lv_s  = ctse_pkg::sx32(ctx5_r.v0) + ctse_pkg::sxm(kl5_r);
    pos_s = ctse_pkg::sx32(ctx8_r.p0) + ctse_pkg::sxm(gw8_r);
    ctx3_nxt      = ctx2_r;
    ctx3_nxt.clip = ctx2_r.clip | ctse_pkg::sat_hit(h_s) | ctse_pkg::sat_hit(kw_s)
                  | ctse_pkg::sat_hit(acc_s) | ctse_pkg::sat_hit(kl_s);
    ctx6_nxt      = ctx5_r;
    ctx6_nxt.clip = ctx5_r.clip | ctse_pkg::sat_hit(g_s) | ctse_pkg::sat_hit(vel_s)
                  | ctse_pkg::sat_hit(lv_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ctse_pkg::POLY_LAT-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    pw1_r  <= ctse_pkg::PROD_W'(ctse_pkg::abs32(a3)) * ctse_pkg::PROD_W'(ctx_in.w);
    pl1_r  <= ctse_pkg::PROD_W'(ctse_pkg::abs32(a3)) * ctse_pkg::PROD_W'(ctx_in.wl);
    neg1_r <= a3[31];
    ctx1_r <= ctx_in;

    mw2_r  <= ctse_pkg::fx_round(neg1_r, pw1_r);
    ml2_r  <= ctse_pkg::fx_round(neg1_r, pl1_r);
    ctx2_r <= ctx1_r;

    h3_r   <= ctse_pkg::sat_val(h_s);
    kw3_r  <= ctse_pkg::sat_val(kw_s);
    acc3_r <= ctse_pkg::sat_val(acc_s);
    kl3_r  <= ctse_pkg::sat_val(kl_s);
    ctx3_r <= ctx3_nxt;

    ph4_r  <= ctse_pkg::PROD_W'(ctse_pkg::abs32(h3_r)) * ctse_pkg::PROD_W'(ctx3_r.w);
    pk4_r  <= ctse_pkg::PROD_W'(ctse_pkg::abs32(kw3_r)) * ctse_pkg::PROD_W'(ctx3_r.w);
    pkl4_r <= ctse_pkg::PROD_W'(ctse_pkg::abs32(kl3_r)) * ctse_pkg::PROD_W'(ctx3_r.wl);
    nh4_r  <= h3_r[31];
    nk4_r  <= kw3_r[31];
    nkl4_r <= kl3_r[31];
    acc4_r <= acc3_r;
    ctx4_r <= ctx3_r;

    hw5_r  <= ctse_pkg::fx_round(nh4_r, ph4_r);
    kw5_r  <= ctse_pkg::fx_round(nk4_r, pk4_r);
    kl5_r  <= ctse_pkg::fx_round(nkl4_r, pkl4_r);
    acc5_r <= acc4_r;
    ctx5_r <= ctx4_r;

    g6_r   <= ctse_pkg::sat_val(g_s);
    vel6_r <= ctse_pkg::sat_val(vel_s);
    lv6_r  <= ctse_pkg::sat_val(lv_s);
    acc6_r <= acc5_r;
    ctx6_r <= ctx6_nxt;

    pg7_r  <= ctse_pkg::PROD_W'(ctse_pkg::abs32(g6_r)) * ctse_pkg::PROD_W'(ctx6_r.w);
    ng7_r  <= g6_r[31];
    vel7_r <= vel6_r;
    lv7_r  <= lv6_r;
    acc7_r <= acc6_r;
    ctx7_r <= ctx6_r;

    gw8_r  <= ctse_pkg::fx_round(ng7_r, pg7_r);
    vel8_r <= vel7_r;
    lv8_r  <= lv7_r;
    acc8_r <= acc7_r;
    ctx8_r <= ctx7_r;

    if (ctx8_r.zero) begin
      pos_r  <= '0;
      vel_r  <= '0;
      acc_r  <= '0;
      lvel_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      pos_r  <= ctse_pkg::sat_val(pos_s);
      vel_r  <= vel8_r;
      acc_r  <= acc8_r;
      lvel_r <= lv8_r;
      sat_r  <= ctx8_r.clip | ctse_pkg::sat_hit(pos_s);
    end
    zero_r <= ctx8_r.zero;
  end

  assign valid_out = vld_r[ctse_pkg::POLY_LAT-1];
  assign pos       = pos_r;
  assign vel       = vel_r;
  assign acc       = acc_r;
  assign lvel      = lvel_r;
  assign zero      = zero_r;
  assign sat       = sat_r;

endmodule

// ===== sv/cubic_trajectory_segment_eval.sv =====
// Top level of the cubic Hermite segment evaluator for one axis.
// The block takes one beat on every clock cycle (busy is always low) and gives each result,
// marked by out_valid for one cycle; results leave in the order the beats came in and the
// receiver cannot hold them off. The result path runs through three chained divider
// passes of 34 stages each, with a quotient bit from each stage but the first and last,
// followed by a nine-stage multiply and accumulate pipeline.
module cubic_trajectory_segment_eval (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_position,
  input  logic [31:0] in_start_velocity,
  input  logic [31:0] in_end_position,
  input  logic [31:0] in_end_velocity,
  input  logic [30:0] in_segment_duration,
  input  logic [30:0] in_phase,
  input  logic [30:0] in_lookahead_phase,
  output logic        out_valid,
  output logic [31:0] out_position_out,
  output logic [31:0] out_velocity_out,
  output logic [31:0] out_acceleration_out,
  output logic [31:0] out_lookahead_velocity,
  output logic        out_zero_duration,
  output logic        out_saturated
);

  logic           s0_vld_r;
  ctse_pkg::ctx_t s0_ctx_r;
  ctse_pkg::num_t dp_r;

  logic           da_vld;
  ctse_pkg::s32_t da_quo;
  logic           da_clip;
  ctse_pkg::ctx_t da_ctx;

  logic           s1_vld_r;
  ctse_pkg::ctx_t s1_ctx_r;
  ctse_pkg::ctx_t s1_ctx_nxt;
  ctse_pkg::num_t n2_r, n3_r;
  ctse_pkg::num_t q_x, v0_x, v1_x;

  logic           db_vld;
  ctse_pkg::s32_t db_quo;
  logic           db_clip;
  ctse_pkg::ctx_t db_ctx;
  logic           dc_vld;
  ctse_pkg::s32_t dc_quo;
  logic           dc_clip;
  ctse_pkg::ctx_t dc_ctx;

  logic           s2_vld_r;
  ctse_pkg::ctx_t s2_ctx_r;
  ctse_pkg::ctx_t s2_ctx_nxt;
  ctse_pkg::num_t n4_r;

  logic           dd_vld;
  ctse_pkg::s32_t dd_quo;
  logic           dd_clip;
  ctse_pkg::ctx_t dd_ctx;
  ctse_pkg::ctx_t pl_ctx;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
      s1_vld_r <= da_vld;
      s2_vld_r <= dc_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_ctx_r.p0   <= in_start_position;
    s0_ctx_r.v0   <= in_start_velocity;
    s0_ctx_r.v1   <= in_end_velocity;
    s0_ctx_r.t    <= in_segment_duration;
    s0_ctx_r.w    <= in_phase;
    s0_ctx_r.wl   <= in_lookahead_phase;
    s0_ctx_r.q    <= '0;
    s0_ctx_r.a2   <= '0;
    s0_ctx_r.zero <= in_segment_duration == '0;
    s0_ctx_r.clip <= 1'b0;
    dp_r <= ctse_pkg::NUM_W'(signed'(in_end_position))
          - ctse_pkg::NUM_W'(signed'(in_start_position));
  end

  ctse_div u_div_dp (
    .clk(clk), .rst_n(rst_n), .valid_in(s0_vld_r), .num(dp_r), .ctx_in(s0_ctx_r),
    .valid_out(da_vld), .quo(da_quo), .clip(da_clip), .ctx_out(da_ctx)
  );

  assign q_x  = ctse_pkg::NUM_W'(da_quo);
  assign v0_x = ctse_pkg::NUM_W'(da_ctx.v0);
  assign v1_x = ctse_pkg::NUM_W'(da_ctx.v1);

  always_comb begin
    s1_ctx_nxt      = da_ctx;
    s1_ctx_nxt.q    = da_quo;
    s1_ctx_nxt.clip = da_ctx.clip | da_clip;
  end

  always_ff @(posedge clk) begin
    s1_ctx_r <= s1_ctx_nxt;
    n2_r <= q_x + (q_x <<< 1) - (v0_x <<< 1) - v1_x;
    n3_r <= v0_x + v1_x - (q_x <<< 1);
  end

  ctse_div u_div_a2 (
    .clk(clk), .rst_n(rst_n), .valid_in(s1_vld_r), .num(n2_r), .ctx_in(s1_ctx_r),
    .valid_out(db_vld), .quo(db_quo), .clip(db_clip), .ctx_out(db_ctx)
  );

  ctse_div u_div_a3a (
    .clk(clk), .rst_n(rst_n), .valid_in(s1_vld_r), .num(n3_r), .ctx_in(s1_ctx_r),
    .valid_out(dc_vld), .quo(dc_quo), .clip(dc_clip), .ctx_out(dc_ctx)
  );

  always_comb begin
    s2_ctx_nxt      = dc_ctx;
    s2_ctx_nxt.a2   = db_quo;
    s2_ctx_nxt.clip = dc_ctx.clip | db_clip | dc_clip;
  end

  always_ff @(posedge clk) begin
    s2_ctx_r <= s2_ctx_nxt;
    n4_r <= ctse_pkg::NUM_W'(dc_quo);
  end

  ctse_div u_div_a3b (
    .clk(clk), .rst_n(rst_n), .valid_in(s2_vld_r), .num(n4_r), .ctx_in(s2_ctx_r),
    .valid_out(dd_vld), .quo(dd_quo), .clip(dd_clip), .ctx_out(dd_ctx)
  );

  always_comb begin
    pl_ctx      = dd_ctx;
    pl_ctx.clip = dd_ctx.clip | dd_clip;
  end

  ctse_poly u_poly (
    .clk(clk), .rst_n(rst_n), .valid_in(dd_vld), .a3(dd_quo), .ctx_in(pl_ctx),
    .valid_out(out_valid), .pos(out_position_out), .vel(out_velocity_out),
    .acc(out_acceleration_out), .lvel(out_lookahead_velocity),
    .zero(out_zero_duration), .sat(out_saturated)
  );

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_duration |-> !out_saturated && out_position_out == '0
      && out_velocity_out == '0 && out_acceleration_out == '0
      && out_lookahead_velocity == '0)
    else $error("zero duration result is not clean");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> s0_vld_r)
    else $error("accepted beat did not enter the pipeline");

  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(s0_vld_r, ctse_pkg::DIV_LAT + 1))
    else $error("divider valid out of step");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    db_vld == dc_vld && (!db_vld || db_ctx == dc_ctx))
    else $error("parallel dividers out of step");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the cubic trajectory segment evaluator.
`timescale 1ns / 1ps

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_start_position;
  logic [31:0] in_start_velocity;
  logic [31:0] in_end_position;
  logic [31:0] in_end_velocity;
  logic [30:0] in_segment_duration;
  logic [30:0] in_phase;
  logic [30:0] in_lookahead_phase;
  logic        out_valid;
  logic [31:0] out_position_out;
  logic [31:0] out_velocity_out;
  logic [31:0] out_acceleration_out;
  logic [31:0] out_lookahead_velocity;
  logic        out_zero_duration;
  logic        out_saturated;

  typedef struct {
    logic [31:0] p0, v0, p1, v1;
    logic [30:0] t, w, wl;
  } segment_t;

  typedef struct {
    logic [31:0] pos, vel, acc, lvel;
    logic        zero, sat;
  } motion_t;

  typedef struct {
    segment_t seg;
    logic     typed;
    motion_t  res;
  } row_t;

  localparam int FB = ctse_pkg::FRAC_BITS;
  localparam int LATENCY = 114;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_RANDOM = 830;

  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [30:0] TMAX = 31'h7fff_ffff;
  localparam logic [30:0] ONE  = 31'h1_0000;

  motion_t expected_motion[$];
  int      errors;
  int      accepted;
  int      results_seen;
  int      idle_cycles;
  int      zero_count;
  int      sat_count;
  logic    clip_flag;

  cubic_trajectory_segment_eval dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) begin
      clip_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint scaled_product(input longint a, input longint b);
    logic        neg;
    logic [63:0] ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r = ((ma * mb) + (64'd1 << (FB - 1))) >> FB;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint scaled_quotient(input longint n, input logic [63:0] t);
    logic        neg;
    logic [63:0] mag, r;
    neg = n < 0;
    mag = ((neg ? -n : n) << FB);
    r = (mag + (t >> 1)) / t;
    return clip32(neg ? -longint'(r) : longint'(r));
  endfunction

  function automatic motion_t hermite_eval(input segment_t s);
    motion_t     r;
    longint      p0, v0, p1, v1, w, wl, q, a2, a3, m, h, g, k;
    logic [63:0] t;
    p0 = longint'(signed'(s.p0));
    v0 = longint'(signed'(s.v0));
    p1 = longint'(signed'(s.p1));
    v1 = longint'(signed'(s.v1));
    t = s.t;
    w = s.w;
    wl = s.wl;
    clip_flag = 1'b0;
    r = '{default: '0};
    if (t == 0) begin
      r.zero = 1'b1;
      return r;
    end
    q = scaled_quotient(p1 - p0, t);
    a2 = scaled_quotient(3 * q - 2 * v0 - v1, t);
    a3 = scaled_quotient(scaled_quotient(v0 + v1 - 2 * q, t), t);
    m = scaled_product(a3, w);
    h = clip32(a2 + m);
    g = clip32(v0 + scaled_product(h, w));
    r.pos = clip32(p0 + scaled_product(g, w));
    k = clip32(2 * a2 + 3 * m);
    r.vel = clip32(v0 + scaled_product(k, w));
    r.acc = clip32(2 * a2 + 6 * m);
    m = scaled_product(a3, wl);
    k = clip32(2 * a2 + 3 * m);
    r.lvel = clip32(v0 + scaled_product(k, wl));
    r.sat = clip_flag;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? MAXV : MINV;
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_time();
    case ($urandom_range(0, 7))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 16));
      default: return 31'($urandom_range(32'h0000_4000, 32'h0008_0000));
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    s.p0 = rand_value();
    s.v0 = rand_value();
    s.p1 = rand_value();
    s.v1 = rand_value();
    s.t = ($urandom_range(0, 40) == 0) ? '0 : rand_time();
    s.w = ($urandom_range(0, 1) == 0) ? 31'($urandom_range(0, s.t)) : rand_time();
    s.wl = rand_time();
    return s;
  endfunction

  task automatic send_segment(input segment_t s, input motion_t exp_res);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_start_position <= s.p0;
    in_start_velocity <= s.v0;
    in_end_position <= s.p1;
    in_end_velocity <= s.v1;
    in_segment_duration <= s.t;
    in_phase <= s.w;
    in_lookahead_phase <= s.wl;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_motion = {expected_motion, exp_res};
    accepted++;
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || start && !busy) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid) begin
        results_seen++;
        if (expected_motion.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          motion_t e;
          e = expected_motion.pop_front();
          check_field("position_out", e.pos, out_position_out);
          check_field("velocity_out", e.vel, out_velocity_out);
          check_field("acceleration_out", e.acc, out_acceleration_out);
          check_field("lookahead_velocity", e.lvel, out_lookahead_velocity);
          check_field("zero_duration", 32'(e.zero), 32'(out_zero_duration));
          check_field("saturated", 32'(e.sat), 32'(out_saturated));
          if (e.zero) zero_count++;
          if (e.sat) sat_count++;
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout waiting for the block");
        $display("Mismatches found");
        $finish;
      end
    end
  end

  row_t directed_rows[$];

  task automatic add_row(input segment_t s, input logic typed, input motion_t r);
    row_t row;
    row.seg = s;
    row.typed = typed;
    row.res = r;
    directed_rows = {directed_rows, row};
  endtask

  initial begin
    motion_t  none;
    motion_t  zero_res;
    motion_t  got;
    segment_t s;
    int       waited;
    none = '{default: '0};
    zero_res = none;
    zero_res.zero = 1'b1;
    errors = 0;
    accepted = 0;
    results_seen = 0;
    idle_cycles = 0;
    zero_count = 0;
    sat_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_start_position = '0;
    in_start_velocity = '0;
    in_end_position = '0;
    in_end_velocity = '0;
    in_segment_duration = '0;
    in_phase = '0;
    in_lookahead_phase = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_row('{MAXV, MAXV, MINV, MINV, 31'd0, TMAX, TMAX}, 1'b1, zero_res);
    add_row('{32'd0, 32'd0, 32'd0, 32'd0, ONE, 31'd0, 31'd0}, 1'b1, none);
    add_row('{32'h1_0000, 32'd0, 32'h1_0000, 32'd0, ONE, ONE, TMAX}, 1'b0, none);
    add_row('{32'd0, 32'd0, 32'h1_0000, 32'd0, ONE, 31'h8000, 31'h8000}, 1'b0, none);
    add_row('{32'd0, 32'h1_0000, 32'h2_0000, 32'h1_0000, 31'h2_0000, ONE, 31'h3_0000},
            1'b0, none);
    add_row('{MINV, 32'd0, MAXV, 32'd0, 31'd1, 31'd1, 31'd1}, 1'b0, none);
    add_row('{MAXV, MAXV, MINV, MINV, TMAX, TMAX, TMAX}, 1'b0, none);
    add_row('{MINV, MINV, MINV, MINV, TMAX, 31'd0, TMAX}, 1'b0, none);
    add_row('{MAXV, MINV, MAXV, MAXV, ONE, 31'h10_0000, 31'd0}, 1'b0, none);
    add_row('{32'hffff_0000, 32'h8000, 32'h3_0000, 32'hfffe_0000, 31'h2_8000,
              31'h5_0000, 31'h1_4000}, 1'b0, none);
    add_row('{32'd5, 32'hffff_fffb, 32'd7, 32'd3, 31'd3, 31'd2, 31'd1}, 1'b0, none);
    add_row('{32'd0, 32'd0, 32'd1, 32'd0, TMAX, TMAX, 31'd0}, 1'b0, none);

    foreach (directed_rows[i]) begin
      got = hermite_eval(directed_rows[i].seg);
      send_segment(directed_rows[i].seg, directed_rows[i].typed ? directed_rows[i].res : got);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      s = rand_segment();
      send_segment(s, hermite_eval(s));
    end
    start <= 1'b0;

    waited = 0;
    while (expected_motion.size() != 0 && waited < 20 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY / 4) @(posedge clk);

    $display("Sent %0d segment beats, checked %0d results", accepted, results_seen);
    $display("Zero-duration results: %0d, saturated results: %0d", zero_count, sat_count);
    if (errors == 0 && expected_motion.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_motion.size() != 0) $error("%0d results never arrived",
                                              expected_motion.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
